// ----- design/etl_pkg.sv -----
// Shared types, codes and helper functions of the expression token lexer.
`timescale 1ns / 1ps
`default_nettype none
package etl_pkg;

  localparam int LEN_W    = 6;   // token length field, holds up to 63
  localparam int PUSH_MAX = 3;   // most commands one request can cause
  localparam int Q_DEPTH  = 4;

  localparam logic [3:0] KIND_INT    = 4'd0;
  localparam logic [3:0] KIND_FLOAT  = 4'd1;
  localparam logic [3:0] KIND_FUNC   = 4'd2;
  localparam logic [3:0] KIND_OP     = 4'd3;
  localparam logic [3:0] KIND_LPAREN = 4'd4;
  localparam logic [3:0] KIND_RPAREN = 4'd5;
  localparam logic [3:0] KIND_SEP    = 4'd6;
  localparam logic [3:0] KIND_ERR    = 4'd7;
  localparam logic [3:0] KIND_END    = 4'd8;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL = 2'd1;
  localparam logic [1:0] ERR_UNEXP   = 2'd2;
  localparam logic [1:0] ERR_LONG    = 2'd3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef enum logic [2:0] {
    CLS_ILLEGAL, CLS_DIGIT, CLS_LETTER, CLS_POINT, CLS_SEP, CLS_OP, CLS_LP, CLS_RP
  } cls_t;

  typedef enum logic [1:0] {LX_NONE, LX_INT, LX_FLOAT, LX_FUNC} lx_state_t;

  typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_DATA} bk_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  token_char;
    logic        token_done;
    logic        right_assoc;
    logic [1:0]  error_code;
    logic [15:0] error_position;
    logic        run_last;
  } out_item_t;

  // One queued command: a single result, or a flush of the token buffer.
  typedef struct packed {
    logic             is_flush;
    logic [3:0]       kind;
    logic [7:0]       ch;
    logic             ra;
    logic [1:0]       ecode;
    logic [15:0]      epos;
    logic             last;
    logic [LEN_W-1:0] len;
  } cmd_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_ILLEGAL;
    if (c inside {[8'h30:8'h39]}) r = CLS_DIGIT;
    else if (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) r = CLS_LETTER;
    else if (c == CH_POINT) r = CLS_POINT;
    else if (c == CH_COMMA) r = CLS_SEP;
    else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) r = CLS_OP;
    else if (c == CH_LPAREN) r = CLS_LP;
    else if (c == CH_RPAREN) r = CLS_RP;
    return r;
  endfunction

  function automatic logic [3:0] token_kind_of(input lx_state_t s);
    logic [3:0] k;
    case (s)
      LX_FLOAT: k = KIND_FLOAT;
      LX_FUNC:  k = KIND_FUNC;
      default:  k = KIND_INT;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] delim_kind_of(input cls_t c);
    logic [3:0] k;
    case (c)
      CLS_OP:  k = KIND_OP;
      CLS_LP:  k = KIND_LPAREN;
      CLS_RP:  k = KIND_RPAREN;
      default: k = KIND_SEP;
    endcase
    return k;
  endfunction

  function automatic cmd_t mk_single(input logic [3:0] kind, input logic [7:0] ch,
                                     input logic ra, input logic [1:0] ecode,
                                     input logic [15:0] epos);
    cmd_t m;
    m          = '0;
    m.kind     = kind;
    m.ch       = ch;
    m.ra       = ra;
    m.ecode    = ecode;
    m.epos     = epos;
    return m;
  endfunction

  function automatic cmd_t mk_flush(input logic [3:0] kind, input logic [LEN_W-1:0] len);
    cmd_t m;
    m          = '0;
    m.is_flush = 1'b1;
    m.kind     = kind;
    m.len      = len;
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- design/etl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module etl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/etl_cmd_fifo.sv -----
// Short command queue between lexer front and emit back; takes up to three per cycle.
`timescale 1ns / 1ps
`default_nettype none
module etl_cmd_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [1:0]   push_n,
  input  etl_pkg::cmd_t     push_cmd [etl_pkg::PUSH_MAX],
  input  wire logic         pop,
  output etl_pkg::cmd_t     head,
  output logic              empty,
  output logic              room
);

  localparam int PTR_W = $clog2(etl_pkg::Q_DEPTH);

  etl_pkg::cmd_t    entries [etl_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  always_ff @(posedge clk) begin
    for (int k = 0; k < etl_pkg::PUSH_MAX; k++) begin
      if (2'(k) < push_n) begin
        entries[wptr + PTR_W'(k)] <= push_cmd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_n);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
    end
  end

  assign head  = entries[rptr];
  assign empty = (count == '0);
  // room for a full burst of commands from one request
  assign room  = (count <= (PTR_W+1)'(etl_pkg::Q_DEPTH - etl_pkg::PUSH_MAX));

endmodule
`default_nettype wire

// ----- design/etl_front.sv -----
// Lexer front: takes requests, classifies bytes, tracks token state, writes the buffer.
`timescale 1ns / 1ps
`default_nettype none
module etl_front #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 src_valid,
  output logic                      src_ready,
  input  etl_pkg::in_item_t         src_item,
  input  wire logic                 room,
  input  wire logic                 flush_done,
  output logic [1:0]                push_n,
  output etl_pkg::cmd_t             push_cmd [etl_pkg::PUSH_MAX],
  output logic                      wr_en,
  output logic [(MAX_TOKEN_LEN > 1 ? $clog2(MAX_TOKEN_LEN) : 1)-1:0] wr_addr,
  output logic [7:0]                wr_data
);

  localparam int ADDR_W = MAX_TOKEN_LEN > 1 ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam int LEN_W  = etl_pkg::LEN_W;

  etl_pkg::lx_state_t       st, st_next;
  logic [LEN_W-1:0]         len, len_next;
  logic                     unary, unary_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic                     skip, skip_next;
  logic                     flush_busy;

  logic                     acc;
  logic [7:0]               c;
  etl_pkg::cls_t            cls;
  logic                     is_delim;
  logic [31:0]              pos_wide;
  logic [15:0]              epos;
  logic                     do_app, do_flush, do_delim, do_err;
  logic [1:0]               err_code;
  logic                     cand_v [4];
  etl_pkg::cmd_t            cand   [4];
  etl_pkg::cmd_t            slot   [4];
  logic [2:0]               n;

  assign src_ready = !flush_busy && room;
  assign acc       = src_valid && src_ready;
  assign c         = src_item.char_code;
  assign cls       = etl_pkg::classify(c);
  assign is_delim  = (cls == etl_pkg::CLS_OP) || (cls == etl_pkg::CLS_LP) ||
                     (cls == etl_pkg::CLS_RP) || (cls == etl_pkg::CLS_SEP);
  assign wr_data   = c;
  assign wr_addr   = len[ADDR_W-1:0];

  always_comb begin
    st_next    = st;
    len_next   = len;
    unary_next = unary;
    pos_next   = (pos == '1) ? pos : pos + POSITION_BITS'(1);
    skip_next  = skip;
    wr_en      = 1'b0;
    do_app     = 1'b0;
    do_flush   = 1'b0;
    do_delim   = 1'b0;
    do_err     = 1'b0;
    err_code   = etl_pkg::ERR_NONE;
    for (int k = 0; k < 4; k++) begin
      cand_v[k] = 1'b0;
      cand[k]   = '0;
    end
    pos_wide = 32'(pos_next);
    epos     = (pos_wide > 32'h0000_FFFF) ? 16'hFFFF : pos_wide[15:0];

    if (acc && !skip && c != etl_pkg::CH_SPACE) begin
      if (cls == etl_pkg::CLS_ILLEGAL) begin
        do_err   = 1'b1;
        err_code = etl_pkg::ERR_ILLEGAL;
      end else begin
        case (st)
          etl_pkg::LX_INT: begin
            if (cls == etl_pkg::CLS_DIGIT) do_app = 1'b1;
            else if (cls == etl_pkg::CLS_POINT) begin
              st_next = etl_pkg::LX_FLOAT;
              do_app  = 1'b1;
            end else if (is_delim) begin
              do_flush = 1'b1;
              do_delim = 1'b1;
            end else begin
              do_err   = 1'b1;
              err_code = etl_pkg::ERR_UNEXP;
            end
          end
          etl_pkg::LX_FLOAT: begin
            if (cls == etl_pkg::CLS_DIGIT) do_app = 1'b1;
            else if (is_delim) begin
              do_flush = 1'b1;
              do_delim = 1'b1;
            end else begin
              do_err   = 1'b1;
              err_code = etl_pkg::ERR_UNEXP;
            end
          end
          etl_pkg::LX_FUNC: begin
            if (cls inside {etl_pkg::CLS_DIGIT, etl_pkg::CLS_LETTER, etl_pkg::CLS_POINT})
              do_app = 1'b1;
            else if (cls == etl_pkg::CLS_LP) begin
              do_flush = 1'b1;
              do_delim = 1'b1;
            end else begin
              do_err   = 1'b1;
              err_code = etl_pkg::ERR_UNEXP;
            end
          end
          default: begin
            if (cls inside {etl_pkg::CLS_OP, etl_pkg::CLS_LP, etl_pkg::CLS_RP})
              do_delim = 1'b1;
            else if (cls == etl_pkg::CLS_DIGIT) begin
              st_next = etl_pkg::LX_INT;
              do_app  = 1'b1;
            end else if (cls == etl_pkg::CLS_LETTER) begin
              st_next = etl_pkg::LX_FUNC;
              do_app  = 1'b1;
            end else if (cls == etl_pkg::CLS_POINT) begin
              st_next = etl_pkg::LX_FLOAT;
              do_app  = 1'b1;
            end else begin
              do_err   = 1'b1;
              err_code = etl_pkg::ERR_UNEXP;
            end
          end
        endcase
      end

      if (do_flush) begin
        cand_v[0]  = 1'b1;
        cand[0]    = etl_pkg::mk_flush(etl_pkg::token_kind_of(st), len);
        unary_next = 1'b0;
        len_next   = '0;
      end
      if (do_delim) begin
        cand_v[1]  = 1'b1;
        cand[1]    = etl_pkg::mk_single(etl_pkg::delim_kind_of(cls), c,
                                        (cls == etl_pkg::CLS_OP) && unary_next,
                                        etl_pkg::ERR_NONE, 16'd0);
        unary_next = (cls == etl_pkg::CLS_LP);
        st_next    = etl_pkg::LX_NONE;
      end
      if (do_app) begin
        if (len >= LEN_W'(MAX_TOKEN_LEN)) begin
          do_err   = 1'b1;
          err_code = etl_pkg::ERR_LONG;
        end else begin
          wr_en    = 1'b1;
          len_next = len + LEN_W'(1);
        end
      end
      if (do_err) begin
        cand_v[1] = 1'b1;
        cand[1]   = etl_pkg::mk_single(etl_pkg::KIND_ERR, c, 1'b0, err_code, epos);
        len_next  = '0;
        st_next   = etl_pkg::LX_NONE;
        skip_next = 1'b1;
      end
    end

    // end of text: flush what is left, then the end marker, then back to reset values
    if (acc && src_item.end_of_text) begin
      if (st_next != etl_pkg::LX_NONE && len_next != '0) begin
        cand_v[2] = 1'b1;
        cand[2]   = etl_pkg::mk_flush(etl_pkg::token_kind_of(st_next), len_next);
      end
      cand_v[3]  = 1'b1;
      cand[3]    = etl_pkg::mk_single(etl_pkg::KIND_END, 8'd0, 1'b0,
                                      etl_pkg::ERR_NONE, 16'd0);
      st_next    = etl_pkg::LX_NONE;
      len_next   = '0;
      unary_next = 1'b1;
      pos_next   = '0;
      skip_next  = 1'b0;
    end

    // pack the active commands to the front; the final one carries run_last
    n = 3'd0;
    for (int k = 0; k < 4; k++) slot[k] = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        slot[n[1:0]] = cand[k];
        n            = n + 3'd1;
      end
    end
    for (int k = 0; k < etl_pkg::PUSH_MAX; k++) begin
      slot[k].last = (3'(k) + 3'd1 == n);
      push_cmd[k]  = slot[k];
    end
    push_n = n[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= etl_pkg::LX_NONE;
      len        <= '0;
      unary      <= 1'b1;
      pos        <= '0;
      skip       <= 1'b0;
      flush_busy <= 1'b0;
    end else begin
      if (acc) begin
        st    <= st_next;
        len   <= len_next;
        unary <= unary_next;
        pos   <= pos_next;
        skip  <= skip_next;
      end
      // buffer is owned by the back until its flush has gone out
      if (acc && (cand_v[0] || cand_v[2])) flush_busy <= 1'b1;
      else if (flush_done)                flush_busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- design/etl_back.sv -----
// Emit back: runs queued commands, reads flushed tokens out of the buffer, holds the result.
`timescale 1ns / 1ps
`default_nettype none
module etl_back #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  etl_pkg::cmd_t      head,
  input  wire logic          empty,
  output logic               pop,
  output logic               rd_en,
  output logic [(MAX_TOKEN_LEN > 1 ? $clog2(MAX_TOKEN_LEN) : 1)-1:0] rd_addr,
  input  wire logic [7:0]    rd_data,
  output logic               flush_done,
  output logic               tok_valid,
  input  wire logic          tok_ready,
  output etl_pkg::out_item_t tok_item
);

  localparam int ADDR_W = MAX_TOKEN_LEN > 1 ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam int LEN_W  = etl_pkg::LEN_W;

  etl_pkg::bk_state_t st, st_next;
  logic [LEN_W-1:0]   idx, idx_next;
  logic [LEN_W-1:0]   flen;
  logic [3:0]         fkind;
  logic               flast;
  logic               latch;
  logic               out_free;
  logic               load;
  logic               fin;
  etl_pkg::out_item_t load_item;

  assign out_free = !tok_valid || tok_ready;
  assign rd_addr  = idx[ADDR_W-1:0];
  assign fin      = (idx + LEN_W'(1) == flen);

  always_comb begin
    st_next    = st;
    idx_next   = idx;
    pop        = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    latch      = 1'b0;
    flush_done = 1'b0;
    load_item  = '0;
    case (st)
      etl_pkg::BK_IDLE: begin
        if (!empty) begin
          if (head.is_flush) begin
            pop      = 1'b1;
            latch    = 1'b1;
            idx_next = '0;
            st_next  = etl_pkg::BK_READ;
          end else if (out_free) begin
            pop                      = 1'b1;
            load                     = 1'b1;
            load_item.token_kind     = head.kind;
            load_item.token_char     = head.ch;
            load_item.token_done     = 1'b1;
            load_item.right_assoc    = head.ra;
            load_item.error_code     = head.ecode;
            load_item.error_position = head.epos;
            load_item.run_last       = head.last;
          end
        end
      end
      etl_pkg::BK_READ: begin
        rd_en   = 1'b1;
        st_next = etl_pkg::BK_DATA;
      end
      etl_pkg::BK_DATA: begin
        if (out_free) begin
          load                 = 1'b1;
          load_item.token_kind = fkind;
          load_item.token_char = rd_data;
          load_item.token_done = fin;
          load_item.run_last   = fin && flast;
          if (fin) begin
            flush_done = 1'b1;
            st_next    = etl_pkg::BK_IDLE;
          end else begin
            idx_next = idx + LEN_W'(1);
            st_next  = etl_pkg::BK_READ;
          end
        end
      end
      default: st_next = etl_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= etl_pkg::BK_IDLE;
      idx       <= '0;
      tok_valid <= 1'b0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
      if (load)           tok_valid <= 1'b1;
      else if (tok_ready) tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      flen  <= head.len;
      fkind <= head.kind;
      flast <= head.last;
    end
    if (load) begin
      tok_item <= load_item;
    end
  end

endmodule
`default_nettype wire

// ----- design/expression_token_lexer_unit.sv -----
// Top level of the expression token lexer: front, command queue, token buffer, back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  src     | in        | src_valid / src_ready  | src_item (char_code, end_of_text)
//  tok     | out       | tok_valid / tok_ready  | tok_item (one token result)
//
// A delimiter or end of text that closes a token queues a flush; the back pops it,
// then reads the token out of the buffer RAM via READ and DATA. Single results
// (operators, parens, separators, errors, end) leave one per cycle while tok_ready
// holds and no flush is read out. Synchronous reset clears all control state; no
// clearing pass. A stalled tok side holds the result register; the front stalls on
// queue room and, once a flush is queued, until its last character has been loaded.
`timescale 1ns / 1ps
`default_nettype none
module expression_token_lexer_unit #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          src_valid,
  output logic               src_ready,
  input  etl_pkg::in_item_t  src_item,
  output logic               tok_valid,
  input  wire logic          tok_ready,
  output etl_pkg::out_item_t tok_item
);

  localparam int ADDR_W = MAX_TOKEN_LEN > 1 ? $clog2(MAX_TOKEN_LEN) : 1;

  logic [1:0]    push_n;
  etl_pkg::cmd_t push_cmd [etl_pkg::PUSH_MAX];
  etl_pkg::cmd_t head;
  logic          empty;
  logic          room;
  logic          pop;
  logic          flush_done;
  logic          wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]    rd_data;

  etl_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .room      (room),
    .flush_done(flush_done),
    .push_n    (push_n),
    .push_cmd  (push_cmd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  etl_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push_n  (push_n),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .room    (room)
  );

  etl_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TOKEN_LEN)
  ) u_buf (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  etl_back #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .flush_done(flush_done),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_item  (tok_item)
  );

endmodule
`default_nettype wire

// ----- design/etl_checker.sv -----
// Port-level checks on the expression token lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module etl_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          tok_valid,
  input wire logic          tok_ready,
  input etl_pkg::out_item_t tok_item
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
    else $error("result changed while stalled");

  a_end: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.token_kind == etl_pkg::KIND_END |->
      tok_item.token_done && tok_item.run_last && tok_item.token_char == 8'd0)
    else $error("malformed end result");

  a_noerr: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.token_kind != etl_pkg::KIND_ERR |->
      tok_item.error_code == etl_pkg::ERR_NONE && tok_item.error_position == 16'd0)
    else $error("error fields set on a non-error result");

  a_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.run_last |-> tok_item.token_done &&
      (tok_item.token_kind == etl_pkg::KIND_END || tok_item.token_kind == etl_pkg::KIND_ERR
       || tok_item.token_kind == etl_pkg::KIND_OP || tok_item.token_kind == etl_pkg::KIND_LPAREN
       || tok_item.token_kind == etl_pkg::KIND_RPAREN || tok_item.token_kind == etl_pkg::KIND_SEP))
    else $error("request ended on a token character");

endmodule

bind expression_token_lexer_unit etl_checker u_etl_checker (
  .clk      (clk),
  .rst      (rst),
  .tok_valid(tok_valid),
  .tok_ready(tok_ready),
  .tok_item (tok_item)
);
`default_nettype wire
